### rtl/wbpm_pkg.sv
// Shared constants, types and helpers for the wildcard byte pattern matcher.
`default_nettype none
package wbpm_pkg;

	localparam int MAX_PATTERN   = 16;
	localparam int POSITION_BITS = 32;
	localparam int WIN_DEPTH     = MAX_PATTERN - 1;
	localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
	localparam int BYTE_W        = 8;
	localparam int START_W       = 32;
	localparam int APB_ADDR_W    = 5;
	localparam int APB_DATA_W    = 64;
	localparam int REG_LEN_W     = 5;

	localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'h3F;

	typedef enum logic [1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2
	} wbpm_reg_t;

	// cmp_bytes[j] is the pattern byte that lines up with the byte j steps back
	// from the current one; active[j] says that byte takes part at all.
	typedef struct packed {
		logic [MAX_PATTERN-1:0][BYTE_W-1:0] cmp_bytes;
		logic [MAX_PATTERN-1:0]             active;
		logic [LEN_W-1:0]                   length;
	} wbpm_cfg_t;

	function automatic logic byte_ok(input logic [BYTE_W-1:0] p, input logic [BYTE_W-1:0] b);
		return (p == WILDCARD_BYTE) || (p == b);
	endfunction

endpackage
`default_nettype wire

### rtl/wbpm_if.sv
// Stream interfaces: incoming buffer bytes and outgoing match results.
`default_nettype none
interface wbpm_byte_if import wbpm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              first_of_buffer;

	modport source (output valid, data_byte, first_of_buffer, input ready);
	modport sink   (input valid, data_byte, first_of_buffer, output ready);
endinterface

interface wbpm_match_if import wbpm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               match_found;
	logic [START_W-1:0] match_start;

	modport source (output valid, match_found, match_start, input ready);
	modport sink   (input valid, match_found, match_start, output ready);
endinterface
`default_nettype wire

### rtl/wbpm_cfg.sv
// APB register file and alignment of the pattern to the current length.
`default_nettype none
module wbpm_cfg import wbpm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output wbpm_cfg_t                  cfg
);

	logic [63:0]            pat_low_q;
	logic [63:0]            pat_high_q;
	logic [REG_LEN_W-1:0]   pat_len_q;
	wbpm_reg_t              reg_sel;
	logic                   wr_en;
	logic [LEN_W-1:0]       len_eff;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_bytes;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] rev_bytes;
	logic [LEN_W+2:0]       shamt;

	assign pready  = 1'b1;
	assign reg_sel = wbpm_reg_t'(paddr[4:3]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= REG_LEN_W'(1);
		end else if (wr_en) begin
			case (reg_sel)
				REG_PATTERN_LOW:    pat_low_q  <= pwdata;
				REG_PATTERN_HIGH:   pat_high_q <= pwdata;
				REG_PATTERN_LENGTH: pat_len_q  <= pwdata[REG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PATTERN_LOW:    prdata = pat_low_q;
			REG_PATTERN_HIGH:   prdata = pat_high_q;
			REG_PATTERN_LENGTH: prdata = {{(APB_DATA_W-REG_LEN_W){1'b0}}, pat_len_q};
			default:            prdata = '0;
		endcase
	end

	// zero counts as one, anything past MAX_PATTERN is clamped to it
	always_comb begin
		if (pat_len_q == '0)
			len_eff = LEN_W'(1);
		else if (int'(pat_len_q) > MAX_PATTERN)
			len_eff = LEN_W'(MAX_PATTERN);
		else
			len_eff = LEN_W'(pat_len_q);
	end

	assign pat_bytes = {pat_high_q, pat_low_q};

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++)
			rev_bytes[k] = pat_bytes[MAX_PATTERN-1-k];
	end

	// cmp_bytes[j] = pattern[len-1-j]: reversed pattern shifted down by MAX-len bytes
	assign shamt = {LEN_W'(LEN_W'(MAX_PATTERN) - len_eff), 3'b000};

	always_comb begin
		cfg.cmp_bytes = rev_bytes >> shamt;
		for (int j = 0; j < MAX_PATTERN; j++)
			cfg.active[j] = (j < int'(len_eff));
		cfg.length = len_eff;
	end

endmodule
`default_nettype wire

### rtl/wbpm_cell.sv
// One window cell: holds a past byte, compares it against its aligned pattern byte.
`default_nettype none
module wbpm_cell import wbpm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              shift_en,
	input  wire logic [BYTE_W-1:0] byte_in,
	input  wire logic [BYTE_W-1:0] pat_byte,
	input  wire logic              active,
	output logic      [BYTE_W-1:0] byte_out,
	output logic                   ok
);

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign ok       = !active || byte_ok(pat_byte, byte_q);

endmodule
`default_nettype wire

### rtl/wildcard_byte_pattern_matcher_top.sv
// Top level: byte window chain, match decision, position counter and result register.
//
// Usage:
//  - byte_in carries one buffer byte per word with first_of_buffer marking
//    offset 0 of a new buffer. match_out returns one word per byte: match_found
//    is set on the byte where the pattern ends, match_start gives the offset
//    of its first byte (0 when no match).
//  - Pattern bytes and length are written over APB (8-byte stride: pattern_low
//    at 0x00, pattern_high at 0x08, pattern_length at 0x10); writes must be made
//    with the stream idle (the block does not enforce this) and apply to the next byte.
//  - Result: registered, valid in the cycle after its byte is accepted.
//  - Throughput: one byte per cycle when not stalled, set by the parallel compare
//    across the window cells and the one-deep result register.
//  - Stall: while a result waits and match_out.ready is low, byte_in.ready is
//    low; when the result is taken in the same cycle a new byte is accepted.
//  - Reset: window fill count 0, offset 0, pattern all zero, length 1, no result held.
//  - After a match the window empties, so matches never overlap, and only
//    bytes since the last first_of_buffer can take part.
`default_nettype none
module wildcard_byte_pattern_matcher_top import wbpm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	wbpm_byte_if.sink                  byte_in,
	wbpm_match_if.source               match_out,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	wbpm_cfg_t            cfg;
	logic [WIN_DEPTH-1:0][BYTE_W-1:0] win;
	logic [WIN_DEPTH-1:0] cell_ok;
	logic                 accept;
	logic                 hit;
	logic                 head_ok;
	logic                 fill_ok;
	logic [LEN_W-1:0]     fill_q;
	logic [LEN_W-1:0]     fill_base;
	logic [LEN_W-1:0]     len_m1;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] cur_pos;
	logic [POSITION_BITS-1:0] diff;
	logic [START_W+POSITION_BITS-1:0] diff_ext;
	logic                 out_valid_q;
	logic                 found_q;
	logic [START_W-1:0]   start_q;

	wbpm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign byte_in.ready = !out_valid_q || match_out.ready;
	assign accept        = byte_in.valid && byte_in.ready;

	// window: cell 0 holds the newest past byte
	for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
		logic [BYTE_W-1:0] cell_in;
		if (j == 0) begin : g_head
			assign cell_in = byte_in.data_byte;
		end else begin : g_tail
			assign cell_in = win[j-1];
		end
		wbpm_cell u_cell (
			.clk      (clk),
			.shift_en (accept && !hit),
			.byte_in  (cell_in),
			.pat_byte (cfg.cmp_bytes[j+1]),
			.active   (cfg.active[j+1]),
			.byte_out (win[j]),
			.ok       (cell_ok[j])
		);
	end

	assign len_m1    = cfg.length - LEN_W'(1);
	assign fill_base = byte_in.first_of_buffer ? '0 : fill_q;
	assign cur_pos   = byte_in.first_of_buffer ? '0 : pos_q;
	assign fill_ok   = fill_base >= len_m1;
	assign head_ok   = byte_ok(cfg.cmp_bytes[0], byte_in.data_byte);
	assign hit       = fill_ok && head_ok && (&cell_ok);

	always_comb begin
		if (cur_pos >= POSITION_BITS'(len_m1))
			diff = cur_pos - POSITION_BITS'(len_m1);
		else
			diff = '0;
	end
	assign diff_ext = {{START_W{1'b0}}, diff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			if (hit)
				fill_q <= '0;
			else if (fill_base < LEN_W'(WIN_DEPTH))
				fill_q <= fill_base + LEN_W'(1);
			else
				fill_q <= fill_base;
			// offset saturates at all ones
			if (&cur_pos)
				pos_q <= cur_pos;
			else
				pos_q <= cur_pos + POSITION_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (match_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_q <= hit;
			start_q <= hit ? diff_ext[START_W-1:0] : '0;
		end
	end

	assign match_out.valid       = out_valid_q;
	assign match_out.match_found = found_q;
	assign match_out.match_start = start_q;

endmodule
`default_nettype wire

### rtl/wbpm_checker.sv
// Port-level checks for the matcher top, attached by bind.
`default_nettype none
module wbpm_checker import wbpm_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               match_found,
	input wire logic [START_W-1:0] match_start,
	input wire logic               pready
);

	// every accepted byte yields a result word on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after accepted byte");

	// a held result blocks new bytes
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("byte accepted while result stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_found) && $stable(match_start))
		else $error("stalled result word changed");

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !match_found |-> match_start == '0)
		else $error("offset nonzero without match");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind wildcard_byte_pattern_matcher_top wbpm_checker u_wbpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (byte_in.valid),
	.in_ready    (byte_in.ready),
	.out_valid   (match_out.valid),
	.out_ready   (match_out.ready),
	.match_found (match_out.match_found),
	.match_start (match_out.match_start),
	.pready      (pready)
);
`default_nettype wire
